// ----- rtl/tsr_pkg.sv -----
// shared types and constants for the timestamp rebase block
`default_nettype none

package tsr_pkg;

    localparam int IN_W  = 264;
    localparam int OUT_W = 208;

    localparam logic [1:0] CFG_BASE_NUM      = 2'd0;
    localparam logic [1:0] CFG_BASE_DEN      = 2'd1;
    localparam logic [1:0] CFG_STREAM_NUMBER = 2'd2;

    localparam logic [1:0] SLOT_DUR = 2'd0;
    localparam logic [1:0] SLOT_PTS = 2'd1;
    localparam logic [1:0] SLOT_DTS = 2'd2;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_PREP  = 10'b0000000010,
        S_CHECK = 10'b0000000100,
        S_SEL   = 10'b0000001000,
        S_MUL   = 10'b0000010000,
        S_DIV   = 10'b0000100000,
        S_FIN   = 10'b0001000000,
        S_FIX1  = 10'b0010000000,
        S_FIX2  = 10'b0100000000,
        S_EMIT  = 10'b1000000000
    } state_t;

    typedef struct packed {
        logic capture;
        logic prep;
        logic load;
        logic mul;
        logic div;
        logic fin;
        logic next_slot;
        logic fix1;
        logic fix2;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic bad;
        logic equal;
        logic need;
        logic last_slot;
        logic mul_done;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// ----- rtl/tsr_ctrl.sv -----
// controller state machine for the timestamp rebase block
`default_nettype none

module tsr_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_tvalid,
    output logic                in_tready,
    input  tsr_pkg::stat_t      stat,
    output tsr_pkg::cmd_t       cmd
);

    tsr_pkg::state_t state_reg;
    tsr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsr_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_tready = (state_reg == tsr_pkg::S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            tsr_pkg::S_IDLE:
            begin
                if (in_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = tsr_pkg::S_PREP;
                end
            end
            tsr_pkg::S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = tsr_pkg::S_CHECK;
            end
            tsr_pkg::S_CHECK:
            begin
                if (stat.bad || stat.equal)
                begin
                    state_next = tsr_pkg::S_EMIT;
                end
                else
                begin
                    state_next = tsr_pkg::S_SEL;
                end
            end
            tsr_pkg::S_SEL:
            begin
                if (stat.need)
                begin
                    cmd.load   = 1'b1;
                    state_next = tsr_pkg::S_MUL;
                end
                else if (stat.last_slot)
                begin
                    state_next = tsr_pkg::S_EMIT;
                end
                else
                begin
                    cmd.next_slot = 1'b1;
                end
            end
            tsr_pkg::S_MUL:
            begin
                cmd.mul = 1'b1;
                if (stat.mul_done)
                begin
                    state_next = tsr_pkg::S_DIV;
                end
            end
            tsr_pkg::S_DIV:
            begin
                cmd.div = 1'b1;
                if (stat.div_done)
                begin
                    state_next = tsr_pkg::S_FIN;
                end
            end
            tsr_pkg::S_FIN:
            begin
                cmd.fin = 1'b1;
                if (stat.last_slot)
                begin
                    state_next = tsr_pkg::S_FIX1;
                end
                else
                begin
                    cmd.next_slot = 1'b1;
                    state_next    = tsr_pkg::S_SEL;
                end
            end
            tsr_pkg::S_FIX1:
            begin
                cmd.fix1   = 1'b1;
                state_next = tsr_pkg::S_FIX2;
            end
            tsr_pkg::S_FIX2:
            begin
                cmd.fix2   = 1'b1;
                state_next = tsr_pkg::S_EMIT;
            end
            tsr_pkg::S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = tsr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tsr_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/tsr_dp.sv -----
// datapath: config registers, item registers, multiplier, divider, dts fixup, output register
`default_nettype none

module tsr_dp #(
    parameter int TIME_WIDTH = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  tsr_pkg::cmd_t                    cmd,
    output tsr_pkg::stat_t                   stat,
    input  wire logic                        cfg_we,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [30:0]                 cfg_data,
    input  wire logic [tsr_pkg::IN_W-1:0]    in_tdata,
    output logic                             out_tvalid,
    input  wire logic                        out_tready,
    output logic [tsr_pkg::OUT_W-1:0]        out_tdata
);

    localparam logic [63:0] MAX_TIME = (64'd1 << (TIME_WIDTH - 1)) - 64'd1;

    function automatic logic [62:0] div_step(input logic [61:0] r, input logic b,
                                             input logic [61:0] d);
        logic [62:0] t;
        logic [62:0] diff;
        t    = {r, b};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d})
        begin
            return {1'b1, diff[61:0]};
        end
        return {1'b0, t[61:0]};
    endfunction

    function automatic logic [63:0] sat_inc(input logic [63:0] v);
        if ($signed(v) < $signed(MAX_TIME))
        begin
            return v + 64'd1;
        end
        return MAX_TIME;
    endfunction

    logic [30:0]  snum_reg;
    logic [30:0]  sden_reg;
    logic [9:0]   sn_reg;
    logic [30:0]  pnum_reg;
    logic [30:0]  pden_reg;
    logic         pbase_reg;
    logic [63:0]  dur_reg;
    logic [63:0]  pts_reg;
    logic         pts_p_reg;
    logic [63:0]  dts_reg;
    logic         dts_p_reg;
    logic [61:0]  mulv_reg;
    logic [61:0]  divv_reg;
    logic [1:0]   slot_reg;
    logic         neg_reg;
    logic [63:0]  mag_reg;
    logic [2:0]   mcnt_reg;
    logic [63:0]  pp_reg;
    logic [127:0] dq_reg;
    logic [61:0]  rem_reg;
    logic [5:0]   dcnt_reg;
    logic         hit_reg;
    logic [63:0]  last_dts_reg;
    logic         last_valid_reg;
    logic         out_valid_reg;
    logic [204:0] out_data_reg;

    logic [63:0]  cur_val;
    logic         cur_need;
    logic [1:0]   prev_idx;
    logic [127:0] pp_shift;
    logic [31:0]  mul_a;
    logic [31:0]  mul_b;
    logic [62:0]  step1;
    logic [62:0]  step2;
    logic         big;
    logic [63:0]  pos_res;
    logic [63:0]  mround;
    logic [63:0]  mclamp;
    logic [63:0]  result;
    logic         hit;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snum_reg <= 31'd1;
            sden_reg <= 31'd1;
            sn_reg   <= 10'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tsr_pkg::CFG_BASE_NUM:      snum_reg <= cfg_data;
                tsr_pkg::CFG_BASE_DEN:      sden_reg <= cfg_data;
                tsr_pkg::CFG_STREAM_NUMBER: sn_reg   <= cfg_data[9:0];
                default:
                begin
                end
            endcase
        end
    end

    // operand selection
    always_comb
    begin
        case (slot_reg)
            tsr_pkg::SLOT_DUR:
            begin
                cur_val  = dur_reg;
                cur_need = !dur_reg[63];
            end
            tsr_pkg::SLOT_PTS:
            begin
                cur_val  = pts_reg;
                cur_need = pts_p_reg;
            end
            default:
            begin
                cur_val  = dts_reg;
                cur_need = dts_p_reg;
            end
        endcase
    end

    // multiplier partial products
    assign mul_a    = mcnt_reg[0] ? mag_reg[63:32] : mag_reg[31:0];
    assign mul_b    = mcnt_reg[1] ? {2'b00, mulv_reg[61:32]} : mulv_reg[31:0];
    assign prev_idx = 2'(mcnt_reg - 3'd1);

    always_comb
    begin
        case (prev_idx)
            2'd0:    pp_shift = {64'd0, pp_reg};
            2'd3:    pp_shift = {pp_reg, 64'd0};
            default: pp_shift = {32'd0, pp_reg, 32'd0};
        endcase
    end

    // two restoring division steps per cycle
    assign step1 = div_step(rem_reg, dq_reg[127], divv_reg);
    assign step2 = div_step(step1[61:0], dq_reg[126], divv_reg);

    // floor rounding and saturation
    assign big     = (|dq_reg[127:64]) || (dq_reg[63:0] > MAX_TIME);
    assign pos_res = big ? MAX_TIME : dq_reg[63:0];
    assign mround  = dq_reg[63:0] + {63'd0, (rem_reg != 62'd0)};
    assign mclamp  = (mround > MAX_TIME) ? MAX_TIME : mround;
    assign result  = !neg_reg ? pos_res : (big ? (64'd0 - MAX_TIME) : (64'd0 - mclamp));

    assign hit = last_valid_reg && (dts_reg == last_dts_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pnum_reg  <= in_tdata[30:0];
            pden_reg  <= in_tdata[61:31];
            pbase_reg <= in_tdata[62];
            dur_reg   <= in_tdata[126:63];
            pts_reg   <= in_tdata[190:127];
            pts_p_reg <= in_tdata[191];
            dts_reg   <= in_tdata[255:192];
            dts_p_reg <= in_tdata[256];
        end
        else if (cmd.fin)
        begin
            case (slot_reg)
                tsr_pkg::SLOT_DUR: dur_reg <= result;
                tsr_pkg::SLOT_PTS: pts_reg <= result;
                default:           dts_reg <= result;
            endcase
        end
        else if (cmd.fix1)
        begin
            if (hit)
            begin
                dts_reg <= sat_inc(last_dts_reg);
                if (pts_p_reg)
                begin
                    pts_reg <= sat_inc(pts_reg);
                end
            end
        end
        else if (cmd.fix2)
        begin
            if (hit_reg && (!pts_p_reg || ($signed(pts_reg) < $signed(dts_reg))))
            begin
                pts_reg   <= dts_reg;
                pts_p_reg <= 1'b1;
            end
        end

        if (cmd.fix1)
        begin
            hit_reg <= hit;
        end

        if (cmd.prep)
        begin
            mulv_reg <= {31'd0, pnum_reg} * {31'd0, sden_reg};
            divv_reg <= {31'd0, pden_reg} * {31'd0, snum_reg};
        end

        if (cmd.prep)
        begin
            slot_reg <= tsr_pkg::SLOT_DUR;
        end
        else if (cmd.next_slot)
        begin
            slot_reg <= slot_reg + 2'd1;
        end

        if (cmd.load)
        begin
            neg_reg  <= cur_val[63];
            mag_reg  <= cur_val[63] ? (64'd0 - cur_val) : cur_val;
            dq_reg   <= '0;
            rem_reg  <= '0;
            mcnt_reg <= '0;
            dcnt_reg <= '0;
        end
        else if (cmd.mul)
        begin
            pp_reg   <= {32'd0, mul_a} * {32'd0, mul_b};
            mcnt_reg <= mcnt_reg + 3'd1;
            if (mcnt_reg != 3'd0)
            begin
                dq_reg <= dq_reg + pp_shift;
            end
        end
        else if (cmd.div)
        begin
            rem_reg  <= step2[61:0];
            dq_reg   <= {dq_reg[125:0], step1[62], step2[62]};
            dcnt_reg <= dcnt_reg + 6'd1;
        end

        if (cmd.emit)
        begin
            out_data_reg <= {dts_p_reg, dts_reg, pts_p_reg, pts_reg, dur_reg, sn_reg, stat.bad};
        end
    end

    // last issued dts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_dts_reg   <= 64'd0;
            last_valid_reg <= 1'b0;
        end
        else if (cmd.fix2)
        begin
            last_dts_reg   <= dts_reg;
            last_valid_reg <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_tvalid = out_valid_reg;
    assign out_tdata  = {3'd0, out_data_reg};

    assign stat.bad       = !pbase_reg || (pnum_reg == 31'd0) || (pden_reg == 31'd0)
                            || (snum_reg == 31'd0) || (sden_reg == 31'd0);
    assign stat.equal     = (mulv_reg == divv_reg);
    assign stat.need      = cur_need;
    assign stat.last_slot = (slot_reg == tsr_pkg::SLOT_DTS);
    assign stat.mul_done  = (mcnt_reg == 3'd4);
    assign stat.div_done  = (dcnt_reg == 6'h3f);
    assign stat.out_free  = !out_valid_reg || out_tready;

endmodule

`default_nettype wire

// ----- rtl/timestamp_rebase_monotonic.sv -----
// top level of the timestamp rebase block
`default_nettype none

// Rescales a packet's duration, pts and dts from the packet time base to the configured
// stream time base as floor(v * pkt_num * stream_den / (pkt_den * stream_num)), saturated,
// raises a rescaled dts that equals the last issued dts by one (saturating) and stamps the
// stream number on each result. One packet is in work at a time. A packet with a missing,
// zero or equal time base goes through prep, check and emit only. Otherwise each value to
// rescale goes through load, a multiply of four 32x32 partial products, a 2-bit-per-cycle
// restoring divider and rounding in the one shared multiply/divide unit, and a value that is
// absent, or a negative duration, is skipped. The finished result sits in an output register
// so the next packet can be taken while it waits.

module timestamp_rebase_monotonic #(
    parameter int TIME_WIDTH = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [30:0]                 cfg_data,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // pkt_base_num, pkt_base_den, pkt_base_present, in_duration, in_pts,
    // in_pts_present, in_dts, in_dts_present, zero fill
    input  wire logic [tsr_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // status, out_stream_number, out_duration, out_pts, out_pts_present,
    // out_dts, out_dts_present, zero fill
    output logic [tsr_pkg::OUT_W-1:0]        m_axis_tdata
);

    tsr_pkg::cmd_t  cmd;
    tsr_pkg::stat_t stat;

    tsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tvalid (s_axis_tvalid),
        .in_tready (s_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tsr_dp #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_tdata   (s_axis_tdata),
        .out_tvalid (m_axis_tvalid),
        .out_tready (m_axis_tready),
        .out_tdata  (m_axis_tdata)
    );

    // one packet in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a packet is in work");

    // a new result is only loaded while a packet is in work
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a packet in work");

    // emit and capture never coincide
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.emit && cmd.capture))
        else $error("result loaded while taking a packet");

endmodule

`default_nettype wire

// ----- tb/sv/timestamp_rebase_monotonic_tb.sv -----
// self-checking testbench for the timestamp rebase block with a scoreboard and stream drivers
`default_nettype none

module timestamp_rebase_monotonic_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] TMAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [30:0] BMAX = 31'h7fff_ffff;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD = 800;

    typedef struct {
        logic [30:0] pnum;
        logic [30:0] pden;
        logic        pbase;
        logic [63:0] dur;
        logic [63:0] pts;
        logic        pts_p;
        logic [63:0] dts;
        logic        dts_p;
    } packet_t;

    typedef struct {
        logic        status;
        logic [9:0]  snum;
        logic [63:0] dur;
        logic [63:0] pts;
        logic        pts_p;
        logic [63:0] dts;
        logic        dts_p;
    } stamp_t;

    class rebase_scoreboard;
        logic [30:0] base_num = 1;
        logic [30:0] base_den = 1;
        logic [9:0]  stream_id = 0;
        logic [63:0] prev_dts = 0;
        logic        prev_dts_ok = 0;
        stamp_t      pending_q[$];
        int          errors = 0;
        int          n_in = 0;
        int          n_bump = 0;
        int          n_nobase = 0;
        int          n_equal = 0;

        function void set_reg(logic [1:0] idx, logic [30:0] val);
            if (idx == tsr_pkg::CFG_BASE_NUM)
                base_num = val;
            else if (idx == tsr_pkg::CFG_BASE_DEN)
                base_den = val;
            else if (idx == tsr_pkg::CFG_STREAM_NUMBER)
                stream_id = val[9:0];
        endfunction

        function logic [63:0] rebase(logic [63:0] v, logic [63:0] mulv, logic [63:0] divv);
            logic        neg;
            logic [63:0] mag;
            logic [127:0] prod;
            logic [127:0] quo;
            logic [127:0] rem;
            logic [127:0] m;
            neg = v[63];
            mag = neg ? -v : v;
            prod = {64'd0, mag} * {64'd0, mulv};
            quo = prod / {64'd0, divv};
            rem = prod % {64'd0, divv};
            if (!neg)
                return (quo > {64'd0, TMAX}) ? TMAX : quo[63:0];
            if (quo > {64'd0, TMAX})
                return -TMAX;
            m = quo + {127'd0, (rem != 0)};
            if (m > {64'd0, TMAX})
                m = {64'd0, TMAX};
            return -m[63:0];
        endfunction

        function logic [63:0] inc_sat(logic [63:0] v);
            return ($signed(v) < $signed(TMAX)) ? v + 64'd1 : TMAX;
        endfunction

        function void note_packet(packet_t p);
            stamp_t e;
            logic [63:0] mulv;
            logic [63:0] divv;
            n_in++;
            e.status = 0;
            e.snum = stream_id;
            e.dur = p.dur;
            e.pts = p.pts;
            e.pts_p = p.pts_p;
            e.dts = p.dts;
            e.dts_p = p.dts_p;
            mulv = 64'(p.pnum) * 64'(base_den);
            divv = 64'(p.pden) * 64'(base_num);
            if (!p.pbase || p.pnum == 0 || p.pden == 0 || base_num == 0 || base_den == 0)
            begin
                e.status = 1;
                n_nobase++;
            end
            else if (mulv == divv)
            begin
                n_equal++;
            end
            else
            begin
                if (!p.dur[63])
                    e.dur = rebase(p.dur, mulv, divv);
                if (p.pts_p)
                    e.pts = rebase(p.pts, mulv, divv);
                if (p.dts_p)
                begin
                    e.dts = rebase(p.dts, mulv, divv);
                    if (prev_dts_ok && e.dts == prev_dts)
                    begin
                        n_bump++;
                        e.dts = inc_sat(prev_dts);
                        if (e.pts_p)
                            e.pts = inc_sat(e.pts);
                        if (!e.pts_p || $signed(e.pts) < $signed(e.dts))
                        begin
                            e.pts = e.dts;
                            e.pts_p = 1;
                        end
                    end
                    prev_dts = e.dts;
                    prev_dts_ok = 1;
                end
            end
            pending_q.push_back(e);
        endfunction

        function void cmp(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
                errors++;
            end
        endfunction

        function void check_result(logic [tsr_pkg::OUT_W-1:0] d);
            stamp_t e;
            if (pending_q.size() == 0)
            begin
                $error("result transfer with no expected result: %h", d);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            cmp("status", 64'(e.status), 64'(d[0]));
            cmp("out_stream_number", 64'(e.snum), 64'(d[10:1]));
            cmp("out_duration", e.dur, d[74:11]);
            cmp("out_pts", e.pts, d[138:75]);
            cmp("out_pts_present", 64'(e.pts_p), 64'(d[139]));
            cmp("out_dts", e.dts, d[203:140]);
            cmp("out_dts_present", 64'(e.dts_p), 64'(d[204]));
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [1:0]                cfg_index;
    logic [30:0]               cfg_data;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    // pkt_base_num, pkt_base_den, pkt_base_present, in_duration, in_pts,
    // in_pts_present, in_dts, in_dts_present, zero fill
    logic [tsr_pkg::IN_W-1:0]  s_axis_tdata;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    // status, out_stream_number, out_duration, out_pts, out_pts_present,
    // out_dts, out_dts_present, zero fill
    logic [tsr_pkg::OUT_W-1:0] m_axis_tdata;

    rebase_scoreboard sb;
    int  idle_pct;
    bit  hold_req;
    int  n_out;

    // sequence generator state
    logic [63:0] seq_dts;
    logic [30:0] seq_num;
    logic [30:0] seq_den;

    timestamp_rebase_monotonic u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // result side: check transfers, random and long stalls
    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                sb.check_result(m_axis_tdata);
                n_out++;
            end
            if (stall > 0)
            begin
                stall--;
                if (stall == 0)
                    m_axis_tready <= 1;
            end
            else if (hold_req)
            begin
                hold_req = 0;
                m_axis_tready <= 0;
                stall = LONG_HOLD;
            end
            else if ($urandom_range(99) < idle_pct)
            begin
                m_axis_tready <= 0;
                stall = $urandom_range(1, 19);
            end
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout after %0d cycles without a transfer", quiet_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic send_packet(packet_t p);
        s_axis_tvalid <= 1;
        s_axis_tdata <= {7'd0, p.dts_p, p.dts, p.pts_p, p.pts, p.dur, p.pbase, p.pden, p.pnum};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_packet(p);
        if ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    // writes all three registers, only called with the block idle
    task automatic set_stream(logic [30:0] num, logic [30:0] den, logic [9:0] id);
        cfg_we <= 1;
        cfg_index <= tsr_pkg::CFG_BASE_NUM;
        cfg_data <= num;
        @(posedge clk);
        cfg_index <= tsr_pkg::CFG_BASE_DEN;
        cfg_data <= den;
        @(posedge clk);
        cfg_index <= tsr_pkg::CFG_STREAM_NUMBER;
        cfg_data <= {21'd0, id};
        @(posedge clk);
        cfg_we <= 0;
        sb.set_reg(tsr_pkg::CFG_BASE_NUM, num);
        sb.set_reg(tsr_pkg::CFG_BASE_DEN, den);
        sb.set_reg(tsr_pkg::CFG_STREAM_NUMBER, {21'd0, id});
    endtask

    task automatic drain;
        s_axis_tvalid <= 0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [63:0] rnd_time();
        logic [63:0] v;
        case ($urandom_range(3))
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(0, 1000000));
            2: v = TMAX - 64'($urandom_range(0, 1000));
            default: v = -(TMAX - 64'($urandom_range(0, 1000)));
        endcase
        if (v == 64'h8000_0000_0000_0000)
            v = -TMAX;
        return v;
    endfunction

    function automatic logic [30:0] rnd_base();
        return $urandom_range(1, 4) == 1 ? 31'($urandom_range(1, 100)) :
                                           31'($urandom_range(1, 32'h7fff_ffff));
    endfunction

    function automatic packet_t mk(logic [30:0] n, logic [30:0] d, logic b, logic [63:0] du,
                                   logic [63:0] pt, logic pp, logic [63:0] dt, logic dp);
        packet_t p;
        p.pnum = n; p.pden = d; p.pbase = b; p.dur = du;
        p.pts = pt; p.pts_p = pp; p.dts = dt; p.dts_p = dp;
        return p;
    endfunction

    function automatic packet_t random_packet();
        packet_t p;
        int sel;
        int k;
        sel = $urandom_range(99);
        p = mk(rnd_base(), rnd_base(), 1'b1, rnd_time(), rnd_time(), 1'($urandom_range(1)),
               rnd_time(), 1'($urandom_range(1)));
        if (sel < 65)
        begin
            // well-formed stream with rounding collisions
            seq_dts = seq_dts + 64'($urandom_range(0, 3000));
            p.pnum = seq_num;
            p.pden = seq_den;
            p.dts = seq_dts;
            p.dts_p = $urandom_range(19) != 0;
            p.pts = seq_dts + 64'($urandom_range(0, 6000)) - 64'($urandom_range(0, 1500));
            p.pts_p = $urandom_range(9) != 0;
            p.dur = $urandom_range(9) == 0 ? -64'($urandom_range(1, 5000)) :
                                             64'($urandom_range(0, 6000));
        end
        else if (sel < 75)
        begin
            k = $urandom_range(1, 5);
            if (64'(sb.base_num) * k <= 64'(BMAX) && 64'(sb.base_den) * k <= 64'(BMAX))
            begin
                p.pnum = 31'(64'(sb.base_num) * k);
                p.pden = 31'(64'(sb.base_den) * k);
            end
            else
            begin
                p.pnum = sb.base_num;
                p.pden = sb.base_den;
            end
        end
        else if (sel < 83)
        begin
            p.pbase = 0;
        end
        return p;
    endfunction

    task automatic run_phase(int count);
        seq_dts = 64'($urandom_range(0, 100000));
        case ($urandom_range(4))
            0: begin seq_num = 1; seq_den = 90000; end
            1: begin seq_num = 1; seq_den = 48000; end
            2: begin seq_num = 1001; seq_den = 30000; end
            3: begin seq_num = 1; seq_den = 1000; end
            default: begin seq_num = 3; seq_den = 7; end
        endcase
        repeat (count) send_packet(random_packet());
        drain();
    endtask

    initial
    begin
        sb = new();
        n_out = 0;
        idle_pct = 20;
        hold_req = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = tsr_pkg::CFG_BASE_NUM;
        cfg_data = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        m_axis_tready = 1;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // reset register values
        run_phase(5);

        set_stream(1, 1000, 7);
        send_packet(mk(1, 90000, 0, 3000, 90000, 1, 90000, 1));
        send_packet(mk(1, 1000, 1, 3000, 90000, 1, 90000, 1));
        send_packet(mk(1, 90000, 1, 3000, 90000, 1, 90000, 1));
        send_packet(mk(1, 90000, 1, 3000, 90010, 1, 90010, 1));
        send_packet(mk(1, 90000, 1, 3000, 0, 0, 90020, 1));
        send_packet(mk(1, 90000, 1, 3000, 10, 1, 90030, 1));
        send_packet(mk(1, 90000, 1, -64'd5, 180000, 1, 180000, 1));
        send_packet(mk(1, 90000, 1, -TMAX, 55, 0, 66, 0));
        send_packet(mk(1, 90000, 1, 1, -64'd1, 1, -64'd91, 1));
        send_packet(mk(1, 90000, 1, 0, -TMAX, 1, -TMAX, 1));
        send_packet(mk(BMAX, 1, 1, TMAX, TMAX, 1, TMAX, 1));
        send_packet(mk(BMAX, 1, 1, TMAX, TMAX, 1, TMAX, 1));
        send_packet(mk(BMAX, 1, 1, TMAX, -TMAX, 1, -TMAX, 1));
        send_packet(mk(1, BMAX, 1, TMAX, 1, 1, 2, 1));
        send_packet(mk(BMAX, BMAX, 1, 1000, 2000, 1, 3000, 1));
        drain();

        set_stream(BMAX, BMAX, 10'h3ff);
        run_phase(215);
        set_stream(1, BMAX, 5);
        hold_req = 1;
        run_phase(215);
        set_stream(BMAX, 1, 10'h200);
        run_phase(215);
        set_stream(1, 90000, 0);
        run_phase(215);
        set_stream(31'($urandom_range(1, 32'h7fff_ffff)), 31'($urandom_range(1, 32'h7fff_ffff)),
                   10'($urandom_range(0, 1023)));
        run_phase(215);
        idle_pct = 0;
        set_stream(1, 1000, 1);
        run_phase(215);

        repeat (300) @(posedge clk);
        $display("covered %0d packets, %0d results: %0d dts bumps, %0d missing base, %0d equal base",
                 sb.n_in, n_out, sb.n_bump, sb.n_nobase, sb.n_equal);
        $display("register settings from unit bases to full-scale bases, stream ids 0 to 1023");
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
